// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPCC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpcc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPCC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcc: next-cycle check failed");

`endif

// File: rtl/rpcc_pkg.sv
// Shared constants, codes and types of the RGB pulse color classifier.
package rpcc_pkg;

    localparam int PULSE_BITS = 17;
    localparam int NUM_CH     = 3;
    localparam int LEVEL_BITS = 8;
    localparam int CLASS_BITS = 5;
    localparam int CFG_IDX_W  = 3;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W  = ((NUM_CH * PULSE_BITS + 7) / 8) * 8;
    localparam int M_FIELDS_W = NUM_CH * LEVEL_BITS + CLASS_BITS;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Calibration reset values
    localparam logic [PULSE_BITS-1:0] WHITE_RESET = PULSE_BITS'(1);
    localparam logic [PULSE_BITS-1:0] BLACK_RESET = PULSE_BITS'(100000);

    // Divider: one quotient bit per stage, remainder holds 255 * |pulse - white|
    localparam int DIV_STEPS = LEVEL_BITS;
    localparam int REM_W     = PULSE_BITS + LEVEL_BITS;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

    // Front pipeline: input, prep, scale, then the divide steps
    localparam int PIPE_DEPTH = DIV_STEPS + 3;

    // Queue between front and back
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHITE_RED,
        REG_BLACK_RED,
        REG_WHITE_GREEN,
        REG_BLACK_GREEN,
        REG_WHITE_BLUE,
        REG_BLACK_BLUE
    } cfg_reg_t;

    typedef enum logic [CLASS_BITS-1:0] {
        CLR_BLACK,
        CLR_DARK_GRAY,
        CLR_GRAY,
        CLR_LIGHT_GRAY,
        CLR_WHITE,
        CLR_YELLOW,
        CLR_ORANGE,
        CLR_DARK_RED,
        CLR_RED,
        CLR_DARK_GREEN,
        CLR_GREEN,
        CLR_DARK_BLUE,
        CLR_BLUE,
        CLR_BROWN,
        CLR_CYAN,
        CLR_MAGENTA,
        CLR_PURPLE,
        CLR_PINK,
        CLR_UNKNOWN
    } color_t;

    typedef logic [PULSE_BITS-1:0] pulse_t;

    // Calibrated levels of one reading; index 0 red, 1 green, 2 blue
    typedef struct packed {
        logic                                 timed_out;
        logic [NUM_CH-1:0][LEVEL_BITS-1:0]    level;
    } item_t;

    // Front to queue write port
    typedef struct packed {
        logic  valid;
        item_t item;
    } item_wr_t;

endpackage

// File: rtl/rpcc_front.sv
// Front pipeline: takes pulse widths and maps them to calibrated levels.
module rpcc_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  rpcc_pkg::pulse_t [rpcc_pkg::NUM_CH-1:0]   in_pulse,
    input  rpcc_pkg::pulse_t [rpcc_pkg::NUM_CH-1:0]   cal_white,
    input  rpcc_pkg::pulse_t [rpcc_pkg::NUM_CH-1:0]   cal_black,
    output rpcc_pkg::item_wr_t                        out
);

    localparam int PB    = rpcc_pkg::PULSE_BITS;
    localparam int NCH   = rpcc_pkg::NUM_CH;
    localparam int LB    = rpcc_pkg::LEVEL_BITS;
    localparam int STEPS = rpcc_pkg::DIV_STEPS;
    localparam int RW    = rpcc_pkg::REM_W;
    localparam int DEPTH = rpcc_pkg::PIPE_DEPTH;

    logic [DEPTH-1:0]                  vld_reg;
    logic [DEPTH-1:1]                  to_reg;
    rpcc_pkg::pulse_t [NCH-1:0]        pulse_reg;
    logic                              timeout_c;
    logic [NCH-1:0][LB-1:0]            level_c;

    // Valid bits: the pipeline never stalls, the top level holds credits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // Input register and timeout flag chain
    always_ff @(posedge clk)
    begin
        pulse_reg <= in_pulse;
        to_reg    <= {to_reg[DEPTH-2:1], timeout_c};
    end

    // Any zero width is a timeout
    always_comb
    begin
        timeout_c = 1'b0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            if (pulse_reg[ch] == '0)
            begin
                timeout_c = 1'b1;
            end
        end
    end

    // One lane per color channel
    for (genvar ch = 0; ch < NCH; ch++)
    begin : g_lane
        logic [PB:0]       a_diff;
        logic [PB:0]       a_negd;
        logic [PB:0]       d_diff;
        logic [PB:0]       d_negd;
        logic [PB-1:0]     a_abs;
        logic [PB-1:0]     d_abs;
        logic              zero_c;
        logic              full_c;
        logic [PB-1:0]     a_abs_reg;
        logic [PB-1:0]     d_abs_reg;
        logic              zero1_reg;
        logic              full1_reg;
        logic [RW-1:0]     scaled_c;
        logic              over_c;
        logic [RW-1:0]     rem_reg [0:STEPS-1];
        logic [PB-1:0]     den_reg [0:STEPS-1];
        logic [LB-1:0]     quo_reg [0:STEPS];
        logic [STEPS:0]    zero_reg;
        logic [STEPS:0]    full_reg;
        logic [RW-1:0]     den_sh [0:STEPS-1];
        logic [STEPS-1:0]  ge;

        // Prep: signed offsets from white, magnitudes and the easy cases. Offset zero
        // or opposite signs gives full scale; timeout or equal calibration gives zero.
        always_comb
        begin
            a_diff = {1'b0, pulse_reg[ch]} - {1'b0, cal_white[ch]};
            d_diff = {1'b0, cal_black[ch]} - {1'b0, cal_white[ch]};
            a_negd = '0 - a_diff;
            d_negd = '0 - d_diff;
            a_abs  = a_diff[PB] ? a_negd[PB-1:0] : a_diff[PB-1:0];
            d_abs  = d_diff[PB] ? d_negd[PB-1:0] : d_diff[PB-1:0];
            zero_c = timeout_c || (d_diff == '0);
            full_c = !zero_c && ((a_diff == '0) || (a_diff[PB] != d_diff[PB]));
        end

        // Scale: numerator 255 * |a|; a quotient of 255 or more clamps to zero
        always_comb
        begin
            scaled_c = (RW'(a_abs_reg) << LB) - RW'(a_abs_reg);
            over_c   = !full1_reg && (a_abs_reg >= d_abs_reg);
        end

        // Restoring divide, most significant quotient bit first
        always_comb
        begin
            for (int j = 0; j < STEPS; j++)
            begin
                den_sh[j] = RW'(den_reg[j]) << (STEPS - 1 - j);
                ge[j]     = rem_reg[j] >= den_sh[j];
            end
        end

        always_ff @(posedge clk)
        begin
            a_abs_reg   <= a_abs;
            d_abs_reg   <= d_abs;
            zero1_reg   <= zero_c;
            full1_reg   <= full_c;
            rem_reg[0]  <= scaled_c;
            den_reg[0]  <= d_abs_reg;
            quo_reg[0]  <= '0;
            zero_reg[0] <= zero1_reg || over_c;
            full_reg[0] <= full1_reg;
            for (int j = 0; j < STEPS - 1; j++)
            begin
                rem_reg[j+1] <= ge[j] ? (rem_reg[j] - den_sh[j]) : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
            end
            for (int j = 0; j < STEPS; j++)
            begin
                quo_reg[j+1]  <= {quo_reg[j][LB-2:0], ge[j]};
                zero_reg[j+1] <= zero_reg[j];
                full_reg[j+1] <= full_reg[j];
            end
        end

        // Level is 255 minus the quotient, or one of the clamped ends
        assign level_c[ch] = zero_reg[STEPS] ? '0 :
                             full_reg[STEPS] ? rpcc_pkg::LEVEL_MAX :
                             rpcc_pkg::LEVEL_MAX - quo_reg[STEPS];
    end

    assign out.valid          = vld_reg[DEPTH-1];
    assign out.item.timed_out = to_reg[DEPTH-1];
    assign out.item.level     = level_c;

endmodule

// File: rtl/rpcc_fifo.sv
// Queue of calibrated readings between front pipeline and back stage.
module rpcc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  rpcc_pkg::item_wr_t  wr,
    input  logic                rd_en,
    output logic                rd_valid,
    output rpcc_pkg::item_t     rd_item
);

    localparam int DEPTH = rpcc_pkg::FIFO_DEPTH;
    localparam int AW    = rpcc_pkg::FIFO_AW;
    localparam int CW    = rpcc_pkg::OCC_W;

    rpcc_pkg::item_t  mem_reg [0:DEPTH-1];
    rpcc_pkg::item_t  rd_item_reg;
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_next;

    // Pointers wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    // Entry storage; the head word is read ahead into a register, with
    // a bypass when the new head is the word written this cycle
    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem_reg[wr_ptr_reg] <= wr.item;
        end
        if (wr.valid && (wr_ptr_reg == rd_ptr_next))
        begin
            rd_item_reg <= wr.item;
        end
        else
        begin
            rd_item_reg <= mem_reg[rd_ptr_next];
        end
    end

    // Fill count
    always_comb
    begin
        unique case ({wr.valid, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = rd_item_reg;

endmodule

// File: rtl/rpcc_back.sv
// Back stage: color classification and the output word register.
module rpcc_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  rpcc_pkg::item_t                       in_item,
    output logic                                  in_pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [rpcc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tuser
);

    localparam int NCH = rpcc_pkg::NUM_CH;
    localparam int LB  = rpcc_pkg::LEVEL_BITS;

    // Truncated average below k is the same as the sum below 3k
    localparam int BR_DIV = 3;
    localparam logic [9:0] SUM_BR50  = 10'(BR_DIV * 50);
    localparam logic [9:0] SUM_BR80  = 10'(BR_DIV * 80);
    localparam logic [9:0] SUM_BR120 = 10'(BR_DIV * 120);
    localparam logic [9:0] SUM_BR200 = 10'(BR_DIV * 200);

    logic [9:0]              r;
    logic [9:0]              g;
    logic [9:0]              b;
    logic [9:0]              sum;
    logic [9:0]              d_rg;
    logic [9:0]              d_gb;
    logic [9:0]              d_rb;
    rpcc_pkg::color_t        cls_c;
    logic                    valid_reg;
    logic [NCH-1:0][LB-1:0]  level_reg;
    logic                    to_reg;
    rpcc_pkg::color_t        class_reg;

    function automatic logic [9:0] absdiff(input logic [9:0] x, input logic [9:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    // Level differences and sum
    always_comb
    begin
        r    = 10'(in_item.level[0]);
        g    = 10'(in_item.level[1]);
        b    = 10'(in_item.level[2]);
        sum  = r + g + b;
        d_rg = absdiff(r, g);
        d_gb = absdiff(g, b);
        d_rb = absdiff(r, b);
    end

    // Ordered threshold rules
    always_comb
    begin
        priority if (r < 10'd30 && g < 10'd30 && b < 10'd30)
            cls_c = rpcc_pkg::CLR_BLACK;
        else if (sum < SUM_BR50 && d_rg < 10'd20 && d_gb < 10'd20 && d_rb < 10'd20)
            cls_c = rpcc_pkg::CLR_DARK_GRAY;
        else if (sum < SUM_BR120 && d_rg < 10'd25 && d_gb < 10'd25 && d_rb < 10'd25)
            cls_c = rpcc_pkg::CLR_GRAY;
        else if (sum < SUM_BR200 && d_rg < 10'd30 && d_gb < 10'd30 && d_rb < 10'd30)
            cls_c = rpcc_pkg::CLR_LIGHT_GRAY;
        else if (r > 10'd200 && g > 10'd200 && b > 10'd200)
            cls_c = rpcc_pkg::CLR_WHITE;
        else if (r > 10'd120 && g > 10'd120 && b < 10'd80 && d_rg < 10'd50)
            cls_c = rpcc_pkg::CLR_YELLOW;
        else if (r > 10'd150 && g > 10'd60 && g < 10'd140 && b < 10'd70)
            cls_c = rpcc_pkg::CLR_ORANGE;
        else if (r > g + 10'd25 && r > b + 10'd25)
            cls_c = (sum < SUM_BR80) ? rpcc_pkg::CLR_DARK_RED : rpcc_pkg::CLR_RED;
        else if (g > r + 10'd40 && g > b + 10'd40)
            cls_c = (sum < SUM_BR80) ? rpcc_pkg::CLR_DARK_GREEN : rpcc_pkg::CLR_GREEN;
        else if (b > r + 10'd40 && b > g + 10'd40)
            cls_c = (sum < SUM_BR80) ? rpcc_pkg::CLR_DARK_BLUE : rpcc_pkg::CLR_BLUE;
        else if (r > 10'd80 && r < 10'd180 && g > 10'd40 && g < 10'd120 && b < 10'd80)
            cls_c = rpcc_pkg::CLR_BROWN;
        else if (g > 10'd150 && b > 10'd150 && r < 10'd100)
            cls_c = rpcc_pkg::CLR_CYAN;
        else if (r > 10'd120 && b > 10'd120 && g < 10'd100)
            cls_c = (r > b + 10'd30) ? rpcc_pkg::CLR_MAGENTA : rpcc_pkg::CLR_PURPLE;
        else if (r > 10'd180 && g > 10'd100 && g < 10'd180 && b > 10'd120 && b < 10'd200)
            cls_c = rpcc_pkg::CLR_PINK;
        else
            cls_c = rpcc_pkg::CLR_UNKNOWN;
    end

    // Take from the queue when the output register is free or draining
    assign in_pop = in_valid && (!valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output word payload
    always_ff @(posedge clk)
    begin
        if (in_pop)
        begin
            level_reg <= in_item.level;
            to_reg    <= in_item.timed_out;
            class_reg <= cls_c;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = rpcc_pkg::M_TDATA_W'({class_reg, level_reg});
    assign m_tuser  = to_reg;

endmodule

// File: rtl/rgb_pulse_color_classifier_unit.sv
// Top level of the RGB pulse color classifier.
//
// Input stream (s_*): one word per reading, three low-pulse widths. A zero
// width flags a timeout. Output stream (m_*): three calibrated levels,
// 0..255, the color class, and the timeout flag on m_tuser.
// Config channel (cfg_*): writes one of six white/black calibration widths;
// cfg_ready is always high and indexes past the list are dropped. Write it
// only while no reading is in flight.
// From input to output word a reading passes the input register, prep,
// scale, eight restoring divide stages (one quotient bit per stage, three
// channels in parallel), queue write and output register. Throughput is
// one reading per cycle while the sink is ready. s_tready is set by a
// credit counter of words between input and queue head; the queue holds
// 16 entries, enough to cover the pipeline so a steady stream never drops
// tready. When m_tready is low the output register holds, the queue fills
// and s_tready falls once 16 readings are pending. Reset empties the
// pipeline and queue and loads white widths of 1 and black widths of 100000.
module rgb_pulse_color_classifier_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // red_pulse [16:0], green_pulse [33:17], blue_pulse [50:34], zero pad
    input  logic [rpcc_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // red_level [7:0], green_level [15:8], blue_level [23:16],
    // color_class [28:24], zero pad
    output logic [rpcc_pkg::M_TDATA_W-1:0]        m_tdata,
    // timed_out [0]
    output logic                                  m_tuser,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rpcc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rpcc_pkg::PULSE_BITS-1:0]       cfg_data
);

    localparam int PB  = rpcc_pkg::PULSE_BITS;
    localparam int NCH = rpcc_pkg::NUM_CH;
    localparam int CW  = rpcc_pkg::OCC_W;

    rpcc_pkg::pulse_t [NCH-1:0]  white_reg;
    rpcc_pkg::pulse_t [NCH-1:0]  black_reg;
    rpcc_pkg::pulse_t [NCH-1:0]  in_pulse;
    logic [CW-1:0]               occ_reg;
    logic [CW-1:0]               occ_next;
    logic                        s_acc;
    logic                        q_pop;
    logic                        q_valid;
    rpcc_pkg::item_wr_t          front_wr;
    rpcc_pkg::item_t             q_item;

    assign cfg_ready = 1'b1;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_reg <= {NCH{rpcc_pkg::WHITE_RESET}};
            black_reg <= {NCH{rpcc_pkg::BLACK_RESET}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rpcc_pkg::cfg_reg_t'(cfg_index))
                rpcc_pkg::REG_WHITE_RED:   white_reg[0] <= cfg_data;
                rpcc_pkg::REG_BLACK_RED:   black_reg[0] <= cfg_data;
                rpcc_pkg::REG_WHITE_GREEN: white_reg[1] <= cfg_data;
                rpcc_pkg::REG_BLACK_GREEN: black_reg[1] <= cfg_data;
                rpcc_pkg::REG_WHITE_BLUE:  white_reg[2] <= cfg_data;
                rpcc_pkg::REG_BLACK_BLUE:  black_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input word
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            in_pulse[ch] = s_tdata[ch*PB +: PB];
        end
    end

    // Credits: words accepted and not yet popped from the queue
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (occ_reg < CW'(rpcc_pkg::FIFO_DEPTH));

    always_comb
    begin
        unique case ({s_acc, q_pop})
            2'b10:   occ_next = occ_reg + 1'b1;
            2'b01:   occ_next = occ_reg - 1'b1;
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    rpcc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_acc),
        .in_pulse  (in_pulse),
        .cal_white (white_reg),
        .cal_black (black_reg),
        .out       (front_wr)
    );

    rpcc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (front_wr),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item)
    );

    rpcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_item  (q_item),
        .in_pop   (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/rpcc_checker.sv
// Port-level checks of the classifier output, bound to the top level.
`include "assert_macros.svh"

module rpcc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rpcc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] cls;
    logic       lvl_zero;
    logic       lvl_dark;
    logic       lvl_bright;

    assign red   = m_tdata[7:0];
    assign green = m_tdata[15:8];
    assign blue  = m_tdata[23:16];
    assign cls   = m_tdata[28:24];

    assign lvl_zero   = (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);
    assign lvl_dark   = (red < 8'd30) && (green < 8'd30) && (blue < 8'd30);
    assign lvl_bright = (red > 8'd200) && (green > 8'd200) && (blue > 8'd200);

    // Stalled output word holds
    `RPCC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tdata, m_tuser}))

    // Timeout gives zero levels and black
    `RPCC_ASSERT_IMP(a_timeout_black, m_tvalid && m_tuser, lvl_zero && cls == rpcc_pkg::CLR_BLACK)

    // Three dark levels always classify as black
    `RPCC_ASSERT_IMP(a_dark_black, m_tvalid && lvl_dark, cls == rpcc_pkg::CLR_BLACK)

    // White only for three bright levels
    `RPCC_ASSERT_IMP(a_white_bright, m_tvalid && cls == rpcc_pkg::CLR_WHITE, lvl_bright)

endmodule

bind rgb_pulse_color_classifier_unit rpcc_checker u_rpcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: sim/tb_rgb_pulse_color_classifier_unit.sv
// Self-checking testbench for the RGB pulse color classifier unit.
`timescale 1ns / 100ps

module tb_rgb_pulse_color_classifier_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CAL_REGS    = 6;
    localparam int PULSE_MAX   = 100000;
    localparam int DRAIN_WAIT  = 40;

    // One expected output word
    typedef struct {
        logic [rpcc_pkg::LEVEL_BITS-1:0] red_level;
        logic [rpcc_pkg::LEVEL_BITS-1:0] green_level;
        logic [rpcc_pkg::LEVEL_BITS-1:0] blue_level;
        logic                            timed_out;
        rpcc_pkg::color_t                color_class;
    } color_reading_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rpcc_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rpcc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [rpcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rpcc_pkg::PULSE_BITS-1:0] cfg_data = '0;

    // Calibration as the block should hold it; index 0 red, 1 green, 2 blue
    rpcc_pkg::pulse_t cal_white [rpcc_pkg::NUM_CH];
    rpcc_pkg::pulse_t cal_black [rpcc_pkg::NUM_CH];

    color_reading_t pending_colors [$];

    int  cycle_count = 0;
    int  mismatches = 0;
    int  readings_sent = 0;
    int  timeouts_sent = 0;
    int  words_checked = 0;
    int  cal_settings = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    bit  jitter_on = 1'b1;
    logic [rpcc_pkg::CLR_UNKNOWN:0] classes_seen = '0;

    rgb_pulse_color_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle limit with %0d words pending",
                     pending_colors.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sink: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !jitter_on || ($urandom_range(99) >= 13);
    end

    // Output checker: each word against the oldest expectation
    always @(posedge clk)
    begin
        color_reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("output word with no reading pending: tdata %h tuser %b",
                       m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_colors.pop_front();
                words_checked++;
                if (m_tdata[7:0] !== want.red_level)
                begin
                    $error("red_level: expected %0d, actual %0d", want.red_level, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[15:8] !== want.green_level)
                begin
                    $error("green_level: expected %0d, actual %0d",
                           want.green_level, m_tdata[15:8]);
                    mismatches++;
                end
                if (m_tdata[23:16] !== want.blue_level)
                begin
                    $error("blue_level: expected %0d, actual %0d",
                           want.blue_level, m_tdata[23:16]);
                    mismatches++;
                end
                if (m_tdata[28:24] !== want.color_class)
                begin
                    $error("color_class: expected %0d, actual %0d",
                           want.color_class, m_tdata[28:24]);
                    mismatches++;
                end
                if (m_tdata[rpcc_pkg::M_TDATA_W-1:29] !== '0)
                begin
                    $error("tdata pad: expected 0, actual %0d",
                           m_tdata[rpcc_pkg::M_TDATA_W-1:29]);
                    mismatches++;
                end
                if (m_tuser !== want.timed_out)
                begin
                    $error("timed_out: expected %0d, actual %0d", want.timed_out, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    // Linear map of a pulse width onto 255..0, truncating signed divide, clamped
    function automatic int scale_channel(rpcc_pkg::pulse_t pulse, rpcc_pkg::pulse_t white,
                                         rpcc_pkg::pulse_t black);
        longint x;
        longint lo;
        longint hi;
        longint v;
        x  = pulse;
        lo = white;
        hi = black;
        if (lo == hi)
            return 0;
        v = ((x - lo) * (-255)) / (hi - lo) + 255;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return int'(v);
    endfunction

    function automatic int absdiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit near_gray(int r, int g, int b, int tol);
        return absdiff(r, g) < tol && absdiff(g, b) < tol && absdiff(r, b) < tol;
    endfunction

    // Ordered threshold rules
    function automatic rpcc_pkg::color_t pick_color_class(int r, int g, int b);
        int br;
        br = (r + g + b) / 3;
        if (r < 30 && g < 30 && b < 30)
            return rpcc_pkg::CLR_BLACK;
        if (br < 50 && near_gray(r, g, b, 20))
            return rpcc_pkg::CLR_DARK_GRAY;
        if (br < 120 && near_gray(r, g, b, 25))
            return rpcc_pkg::CLR_GRAY;
        if (br < 200 && near_gray(r, g, b, 30))
            return rpcc_pkg::CLR_LIGHT_GRAY;
        if (r > 200 && g > 200 && b > 200)
            return rpcc_pkg::CLR_WHITE;
        if (r > 120 && g > 120 && b < 80 && absdiff(r, g) < 50)
            return rpcc_pkg::CLR_YELLOW;
        if (r > 150 && g > 60 && g < 140 && b < 70)
            return rpcc_pkg::CLR_ORANGE;
        if (r > g + 25 && r > b + 25)
            return (br < 80) ? rpcc_pkg::CLR_DARK_RED : rpcc_pkg::CLR_RED;
        if (g > r + 40 && g > b + 40)
            return (br < 80) ? rpcc_pkg::CLR_DARK_GREEN : rpcc_pkg::CLR_GREEN;
        if (b > r + 40 && b > g + 40)
            return (br < 80) ? rpcc_pkg::CLR_DARK_BLUE : rpcc_pkg::CLR_BLUE;
        if (r > 80 && r < 180 && g > 40 && g < 120 && b < 80)
            return rpcc_pkg::CLR_BROWN;
        if (g > 150 && b > 150 && r < 100)
            return rpcc_pkg::CLR_CYAN;
        if (r > 120 && b > 120 && g < 100)
            return (r > b + 30) ? rpcc_pkg::CLR_MAGENTA : rpcc_pkg::CLR_PURPLE;
        if (r > 180 && g > 100 && g < 180 && b > 120 && b < 200)
            return rpcc_pkg::CLR_PINK;
        return rpcc_pkg::CLR_UNKNOWN;
    endfunction

    // Expected word for one reading under the current calibration
    function automatic color_reading_t classify_reading(rpcc_pkg::pulse_t rp,
                                                        rpcc_pkg::pulse_t gp,
                                                        rpcc_pkg::pulse_t bp);
        color_reading_t res;
        int r;
        int g;
        int b;
        r = 0;
        g = 0;
        b = 0;
        res.timed_out = (rp == 0 || gp == 0 || bp == 0);
        if (!res.timed_out)
        begin
            r = scale_channel(rp, cal_white[0], cal_black[0]);
            g = scale_channel(gp, cal_white[1], cal_black[1]);
            b = scale_channel(bp, cal_white[2], cal_black[2]);
        end
        res.red_level   = r[rpcc_pkg::LEVEL_BITS-1:0];
        res.green_level = g[rpcc_pkg::LEVEL_BITS-1:0];
        res.blue_level  = b[rpcc_pkg::LEVEL_BITS-1:0];
        res.color_class = pick_color_class(r, g, b);
        return res;
    endfunction

    // Pulse width that should land near a given level on one channel
    function automatic rpcc_pkg::pulse_t pulse_for_level(int ch, int lv);
        longint w;
        longint k;
        longint t;
        w = cal_white[ch];
        k = cal_black[ch];
        t = w + ((255 - lv) * (k - w)) / 255 + longint'($urandom_range(2)) - 1;
        if (t < 1)
            t = 1;
        if (t > PULSE_MAX)
            t = PULSE_MAX;
        return rpcc_pkg::pulse_t'(t);
    endfunction

    // Offer one reading and wait for the handshake; called at a rising edge
    task automatic send_reading(input rpcc_pkg::pulse_t rp, input rpcc_pkg::pulse_t gp,
                                input rpcc_pkg::pulse_t bp);
        color_reading_t want;
        if (jitter_on && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rpcc_pkg::S_TDATA_W - rpcc_pkg::NUM_CH * rpcc_pkg::PULSE_BITS){1'b0}},
                     bp, gp, rp};
        do
            @(posedge clk);
        while (!s_tready);
        want = classify_reading(rp, gp, bp);
        pending_colors.push_back(want);
        classes_seen[want.color_class] = 1'b1;
        readings_sent++;
        if (want.timed_out)
            timeouts_sent++;
    endtask

    // Stop offering and wait until every word is back and the pipe is empty
    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_colors.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // One config word; leaves cfg_valid high for back-to-back writes
    task automatic cfg_write(input logic [rpcc_pkg::CFG_IDX_W-1:0] idx,
                             input rpcc_pkg::pulse_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            rpcc_pkg::REG_WHITE_RED:   cal_white[0] = value;
            rpcc_pkg::REG_BLACK_RED:   cal_black[0] = value;
            rpcc_pkg::REG_WHITE_GREEN: cal_white[1] = value;
            rpcc_pkg::REG_BLACK_GREEN: cal_black[1] = value;
            rpcc_pkg::REG_WHITE_BLUE:  cal_white[2] = value;
            rpcc_pkg::REG_BLACK_BLUE:  cal_black[2] = value;
            default: ;
        endcase
    endtask

    task automatic set_calibration(input rpcc_pkg::pulse_t wr, input rpcc_pkg::pulse_t kr,
                                   input rpcc_pkg::pulse_t wg, input rpcc_pkg::pulse_t kg,
                                   input rpcc_pkg::pulse_t wb, input rpcc_pkg::pulse_t kb);
        drain_outputs();
        cfg_write(rpcc_pkg::REG_WHITE_RED, wr);
        cfg_write(rpcc_pkg::REG_BLACK_RED, kr);
        cfg_write(rpcc_pkg::REG_WHITE_GREEN, wg);
        cfg_write(rpcc_pkg::REG_BLACK_GREEN, kg);
        cfg_write(rpcc_pkg::REG_WHITE_BLUE, wb);
        cfg_write(rpcc_pkg::REG_BLACK_BLUE, kb);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cal_settings++;
    endtask

    // Random calibration: mostly wide, some tight, inverted or equal
    task automatic random_calibration();
        rpcc_pkg::pulse_t w [rpcc_pkg::NUM_CH];
        rpcc_pkg::pulse_t k [rpcc_pkg::NUM_CH];
        int mode;
        for (int ch = 0; ch < rpcc_pkg::NUM_CH; ch++)
        begin
            mode = $urandom_range(9);
            if (mode < 6)
            begin
                w[ch] = $urandom_range(1, 5000);
                k[ch] = $urandom_range(w[ch] + 1, PULSE_MAX);
            end
            else if (mode < 8)
            begin
                w[ch] = $urandom_range(1, PULSE_MAX - 400);
                k[ch] = w[ch] + $urandom_range(1, 400);
            end
            else if (mode == 8)
            begin
                k[ch] = $urandom_range(1, PULSE_MAX / 2);
                w[ch] = $urandom_range(k[ch] + 1, PULSE_MAX);
            end
            else
            begin
                w[ch] = $urandom_range(1, PULSE_MAX);
                k[ch] = w[ch];
            end
        end
        set_calibration(w[0], k[0], w[1], k[1], w[2], k[2]);
    endtask

    // Random reading: timeouts, raw widths, near-gray and free level triples
    task automatic random_reading();
        rpcc_pkg::pulse_t p [rpcc_pkg::NUM_CH];
        int mode;
        int base;
        int lv;
        logic [rpcc_pkg::NUM_CH-1:0] zero_mask;
        mode = $urandom_range(99);
        base = $urandom_range(255);
        zero_mask = $urandom_range(1, 7);
        for (int ch = 0; ch < rpcc_pkg::NUM_CH; ch++)
        begin
            if (mode < 8)
                p[ch] = zero_mask[ch] ? rpcc_pkg::pulse_t'(0)
                                      : rpcc_pkg::pulse_t'($urandom_range(PULSE_MAX));
            else if (mode < 25)
                p[ch] = $urandom_range(1, PULSE_MAX);
            else
            begin
                if (mode < 55)
                    lv = base + $urandom_range(50) - 25;
                else
                    lv = $urandom_range(255);
                if (lv < 0)
                    lv = 0;
                if (lv > 255)
                    lv = 255;
                p[ch] = pulse_for_level(ch, lv);
            end
        end
        send_reading(p[0], p[1], p[2]);
    endtask

    // Reset calibration: width extremes, each timeout, alternating bit patterns
    task automatic test_reset_calibration();
        send_reading(1, 1, 1);
        send_reading(PULSE_MAX, PULSE_MAX, PULSE_MAX);
        send_reading(0, 500, 500);
        send_reading(500, 0, 500);
        send_reading(500, 500, 0);
        send_reading(0, 0, 0);
        send_reading(17'h0AAAA, 17'h15555, 17'h10000);
        send_reading(50000, 1, 99999);
    endtask

    // White 1 / black 256 makes pulse = 256 - level, so levels can be aimed
    task automatic test_color_classes();
        int aim [18][3] = '{
            '{10, 10, 10},   '{40, 40, 40},   '{100, 100, 100}, '{180, 180, 180},
            '{230, 230, 230}, '{200, 200, 40}, '{220, 100, 30},  '{100, 20, 20},
            '{250, 40, 40},  '{20, 120, 20},  '{40, 220, 40},   '{20, 20, 150},
            '{40, 40, 240},  '{130, 110, 70}, '{40, 200, 200},  '{122, 99, 130},
            '{220, 179, 199}, '{200, 100, 200}
        };
        set_calibration(1, 256, 1, 256, 1, 256);
        // writes past the register list must leave calibration alone
        cfg_write(CAL_REGS, 5);
        cfg_write(CAL_REGS + 1, 7);
        cfg_valid <= 1'b0;
        @(posedge clk);
        foreach (aim[i])
            send_reading(256 - aim[i][0], 256 - aim[i][1], 256 - aim[i][2]);
        // beyond black clamps to 0
        send_reading(300, 257, PULSE_MAX);
    endtask

    // Inverted, equal and mixed extreme calibrations
    task automatic test_calibration_corners();
        set_calibration(PULSE_MAX, 1, PULSE_MAX, 1, PULSE_MAX, 1);
        send_reading(1, 50000, PULSE_MAX);
        repeat (25) random_reading();
        set_calibration(1, 1, PULSE_MAX, PULSE_MAX, 777, 777);
        send_reading(1, PULSE_MAX, 777);
        repeat (25) random_reading();
        set_calibration(1, PULSE_MAX, PULSE_MAX, 1, 50000, 50000);
        repeat (25) random_reading();
    endtask

    // Sink holds off long enough for the block to fill and drop s_tready
    task automatic test_backpressure();
        drain_outputs();
        jitter_on = 1'b0;
        @(negedge clk);
        hold_req = 300;
        @(posedge clk);
        repeat (80) random_reading();
        drain_outputs();
        jitter_on = 1'b1;
    endtask

    // Bulk random run over several calibrations; one phase with no idling
    task automatic test_random_readings();
        for (int phase = 0; phase < 7; phase++)
        begin
            random_calibration();
            jitter_on = (phase != 3);
            repeat (150) random_reading();
        end
        drain_outputs();
        jitter_on = 1'b1;
    endtask

    initial
    begin
        for (int ch = 0; ch < rpcc_pkg::NUM_CH; ch++)
        begin
            cal_white[ch] = rpcc_pkg::WHITE_RESET;
            cal_black[ch] = rpcc_pkg::BLACK_RESET;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_calibration();
        test_color_classes();
        test_calibration_corners();
        test_backpressure();
        test_random_readings();

        drain_outputs();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_colors.size());
            mismatches++;
        end

        $display("Sent %0d readings (%0d timeouts), checked %0d words, %0d calibrations",
                 readings_sent, timeouts_sent, words_checked, cal_settings);
        $display("Color classes reached: %0d of 19, mismatches: %0d",
                 $countones(classes_seen), mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
